>>> hw/rtl/fbgl_pkg.sv
// Shared types, constants and helpers for the bilinear grid lookup.
// No dependencies; fbgl_front, fbgl_back and the top level import this package.
package fbgl_pkg;

    // Default geometry and number format
    localparam int GRID_DIM_DEF  = 1441;
    localparam int FRAC_BITS_DEF = 8;

    // Fixed field widths of the request and result items
    localparam int ROWCOL_W = 11;
    localparam int CELL_W   = 8;
    localparam int QUERY_W  = 19;
    localparam int VALUE_W  = 16;

    // Queue depths between the parts
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // Configuration port
    localparam int           APB_ADDR_W  = 3;
    localparam int           APB_DATA_W  = 32;
    localparam logic         REG_CLAMP   = 1'b0;
    localparam logic [7:0]   CLAMP_RESET = 8'd100;

    // Request action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Job kinds handed from the front to the back
    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_QUERY,
        KIND_OOR
    } t_kind;

    // Back-end sequencer states
    typedef enum logic {
        SEQ_IDLE,
        SEQ_READ
    } t_seq_state;

    typedef struct packed {
        logic                action;
        logic [ROWCOL_W-1:0] write_row;
        logic [ROWCOL_W-1:0] write_col;
        logic [CELL_W-1:0]   write_value;
        logic [QUERY_W-1:0]  query_x;
        logic [QUERY_W-1:0]  query_y;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] interp_value;
        logic               was_clamped;
        logic               out_of_range;
    } t_out_item;

    // Width of one packed job: kind, cell address, write value, four weights
    function automatic int job_width(input int grid_dim, input int frac_bits);
        int addr_w;
        addr_w = $clog2(grid_dim * grid_dim);
        return $bits(t_kind) + addr_w + CELL_W + 4 * (2 * frac_bits + 1);
    endfunction

endpackage

>>> hw/rtl/fbgl_fifo.sv
// Small register queue with push/full and pop/empty sides.
// Depends on nothing; DEPTH must be a power of two.
module fbgl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (do_push && !do_pop) r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

>>> hw/rtl/fbgl_front.sv
// Front end: accepts requests, range-checks them, forms cell addresses
// and bilinear weights, and pushes jobs to the middle queue. Uses fbgl_pkg.
module fbgl_front
    import fbgl_pkg::*;
#(
    parameter int GRID_DIM  = GRID_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_item i_item,
    input  logic     i_push,
    output logic     o_full,
    output logic     o_mid_push,
    output logic [job_width(GRID_DIM, FRAC_BITS)-1:0] o_mid_job,
    input  logic     i_mid_full
);
    localparam int IDX_W  = $clog2(GRID_DIM);
    localparam int ADDR_W = $clog2(GRID_DIM * GRID_DIM);
    localparam int WGT_W  = 2 * FRAC_BITS + 1;
    localparam int FRC_W  = FRAC_BITS + 1;

    typedef struct packed {
        t_kind                        kind;
        logic [ADDR_W-1:0]            addr;
        logic [CELL_W-1:0]            value;
        logic [3:0][WGT_W-1:0]        wgt;
    } t_job;

    logic                  en;
    logic                  accept;
    logic [31:0]           ix_full;
    logic [31:0]           iy_full;
    logic                  q_oor;
    logic                  w_ok;
    logic [IDX_W-1:0]      row_sel;
    logic [IDX_W-1:0]      col_sel;
    logic [FRC_W-1:0]      fx;
    logic [FRC_W-1:0]      fy;
    logic [FRC_W-1:0]      gx;
    logic [FRC_W-1:0]      gy;
    t_kind                 kind_in;

    logic                  r_s1_valid;
    t_kind                 r_s1_kind;
    logic [ADDR_W-1:0]     r_s1_prod;
    logic [IDX_W-1:0]      r_s1_col;
    logic [CELL_W-1:0]     r_s1_value;
    logic [3:0][WGT_W-1:0] r_s1_wgt;
    t_job                  job;

    // Stage advances whenever its slot drains into the queue
    assign en     = !r_s1_valid || !i_mid_full;
    assign o_full = !en;
    assign accept = i_push && en;

    // Classify the request
    assign ix_full = 32'(i_item.query_x >> FRAC_BITS);
    assign iy_full = 32'(i_item.query_y >> FRAC_BITS);
    assign q_oor   = (ix_full > 32'(GRID_DIM - 2)) || (iy_full > 32'(GRID_DIM - 2));
    assign w_ok    = (32'(i_item.write_row) < 32'(GRID_DIM))
                  && (32'(i_item.write_col) < 32'(GRID_DIM));

    always_comb begin
        if (i_item.action == ACT_WRITE) begin
            kind_in = KIND_WRITE;
            row_sel = i_item.write_row[IDX_W-1:0];
            col_sel = i_item.write_col[IDX_W-1:0];
        end else begin
            kind_in = q_oor ? KIND_OOR : KIND_QUERY;
            row_sel = iy_full[IDX_W-1:0];
            col_sel = ix_full[IDX_W-1:0];
        end
    end

    // Fractions and their complements
    assign fx = FRC_W'(i_item.query_x[FRAC_BITS-1:0]);
    assign fy = FRC_W'(i_item.query_y[FRAC_BITS-1:0]);
    assign gx = (FRC_W'(1) << FRAC_BITS) - fx;
    assign gy = (FRC_W'(1) << FRAC_BITS) - fy;

    // Stage 1: row product and the four weights
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept && ((i_item.action == ACT_QUERY) || w_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_kind   <= kind_in;
            r_s1_prod   <= ADDR_W'(row_sel) * ADDR_W'(GRID_DIM);
            r_s1_col    <= col_sel;
            r_s1_value  <= i_item.write_value;
            r_s1_wgt[0] <= WGT_W'(gx) * WGT_W'(gy);
            r_s1_wgt[1] <= WGT_W'(fx) * WGT_W'(gy);
            r_s1_wgt[2] <= WGT_W'(fx) * WGT_W'(fy);
            r_s1_wgt[3] <= WGT_W'(gx) * WGT_W'(fy);
        end
    end

    // Job out to the middle queue
    always_comb begin
        job.kind  = r_s1_kind;
        job.addr  = r_s1_prod + ADDR_W'(r_s1_col);
        job.value = r_s1_value;
        job.wgt   = r_s1_wgt;
    end

    assign o_mid_push = r_s1_valid && !i_mid_full;
    assign o_mid_job  = job;

endmodule

>>> hw/rtl/fbgl_back.sv
// Back end: grid memory, four-read sequencer and weighted-sum pipeline.
// Pops jobs from the middle queue, pushes results. Uses fbgl_pkg.
module fbgl_back
    import fbgl_pkg::*;
#(
    parameter int GRID_DIM  = GRID_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [job_width(GRID_DIM, FRAC_BITS)-1:0] i_job,
    input  logic        i_job_empty,
    output logic        o_job_pop,
    input  logic [7:0]  i_clamp_limit,
    input  logic        i_res_taken,
    output logic        o_res_push,
    output t_out_item   o_res
);
    localparam int CELLS  = GRID_DIM * GRID_DIM;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int WGT_W  = 2 * FRAC_BITS + 1;
    localparam int ACC_W  = 2 * FRAC_BITS + 8;
    localparam int CRD_W  = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        t_kind                 kind;
        logic [ADDR_W-1:0]     addr;
        logic [CELL_W-1:0]     value;
        logic [3:0][WGT_W-1:0] wgt;
    } t_job;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             oor;
        logic [WGT_W-1:0] wgt;
    } t_tag;

    t_job              head;
    t_job              r_job;
    t_seq_state        r_state;
    t_seq_state        n_state;
    logic [1:0]        r_phase;
    logic [CRD_W-1:0]  r_credit;
    logic [CRD_W-1:0]  n_credit;
    logic              can_go;
    logic              take_credit;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [ADDR_W-1:0] nb_offset;
    t_tag              tag0;

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdata;
    t_tag              r_t1;
    t_tag              r_t2;
    t_tag              r_t3;
    logic [ACC_W-1:0]  r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  limit_full;
    logic              over;

    assign head   = i_job;
    assign can_go = !i_job_empty && ((head.kind == KIND_WRITE) || (r_credit != '0));

    // Neighbor offset for the held query: east, south-east, south
    always_comb begin
        case (r_phase)
            2'd1:    nb_offset = ADDR_W'(1);
            2'd2:    nb_offset = ADDR_W'(GRID_DIM + 1);
            default: nb_offset = ADDR_W'(GRID_DIM);
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SEQ_IDLE: if (can_go && head.kind == KIND_QUERY) n_state = SEQ_READ;
            SEQ_READ: if (r_phase == 2'd3) n_state = SEQ_IDLE;
            default:  n_state = SEQ_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_job_pop   = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = head.addr;
        take_credit = 1'b0;
        tag0        = '0;
        unique case (r_state)
            SEQ_IDLE: begin
                o_job_pop   = can_go;
                mem_we      = can_go && (head.kind == KIND_WRITE);
                take_credit = can_go && (head.kind != KIND_WRITE);
                tag0.valid  = take_credit;
                tag0.first  = 1'b1;
                tag0.last   = (head.kind == KIND_OOR);
                tag0.oor    = (head.kind == KIND_OOR);
                tag0.wgt    = head.wgt[0];
            end
            SEQ_READ: begin
                mem_addr    = r_job.addr + nb_offset;
                tag0.valid  = 1'b1;
                tag0.last   = (r_phase == 2'd3);
                tag0.wgt    = r_job.wgt[r_phase];
            end
            default: begin
                o_job_pop = 1'b0;
            end
        endcase
    end

    // Result slots not yet promised to a job
    assign n_credit = r_credit - CRD_W'(take_credit) + CRD_W'(i_res_taken);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SEQ_IDLE;
            r_phase  <= 2'd0;
            r_credit <= CRD_W'(OUT_DEPTH);
        end else begin
            r_state  <= n_state;
            r_credit <= n_credit;
            if (r_state == SEQ_IDLE) r_phase <= 2'd1;
            else                     r_phase <= r_phase + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) r_job <= head;
    end

    // Single-port grid memory
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= head.value;
        r_rdata <= r_mem[mem_addr];
    end

    // Tag pipeline alongside read, multiply and accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_t3 <= '0;
        end else begin
            r_t1 <= tag0;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= ACC_W'(r_t1.wgt * ACC_W'(r_rdata));
        if (r_t2.valid) r_acc <= (r_t2.first ? '0 : r_acc) + r_prod;
    end

    // Truncate and clamp
    assign limit_full = ACC_W'(i_clamp_limit) << (2 * FRAC_BITS);
    assign over       = r_acc > limit_full;

    always_comb begin
        o_res_push = r_t3.valid && r_t3.last;
        if (r_t3.oor) begin
            o_res.interp_value = '0;
            o_res.was_clamped  = 1'b0;
            o_res.out_of_range = 1'b1;
        end else if (over) begin
            o_res.interp_value = {i_clamp_limit, 8'h00};
            o_res.was_clamped  = 1'b1;
            o_res.out_of_range = 1'b0;
        end else begin
            o_res.interp_value = VALUE_W'(r_acc >> (2 * FRAC_BITS - 8));
            o_res.was_clamped  = 1'b0;
            o_res.out_of_range = 1'b0;
        end
    end

endmodule

>>> hw/rtl/fraction_bilinear_grid_lookup.sv
// Bilinear lookup into a GRID_DIM x GRID_DIM grid of 8-bit cells: a write
// request takes one write in the back end, a query request four reads of
// the single-port grid memory, and no new job starts until those reads are
// issued; writes sustain one a cycle while the middle queue holds them.
// Cells hold nothing defined until written and there is no clearing pass
// after reset. Depends on fbgl_pkg, fbgl_fifo, fbgl_front and fbgl_back.
module fraction_bilinear_grid_lookup
    import fbgl_pkg::*;
#(
    parameter int GRID_DIM  = GRID_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request queue side
    input  t_in_item              i_item,
    input  logic                  push,
    output logic                  full,
    // Result queue side
    output t_out_item             o_result,
    output logic                  empty,
    input  logic                  pop,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    localparam int JOB_W = job_width(GRID_DIM, FRAC_BITS);

    logic              mid_push;
    logic              mid_full;
    logic              mid_pop;
    logic              mid_empty;
    logic [JOB_W-1:0]  mid_in;
    logic [JOB_W-1:0]  mid_out;
    logic              res_push;
    logic              res_full;
    logic              res_taken;
    t_out_item         res_item;
    logic [$bits(t_out_item)-1:0] res_head;
    logic [7:0]        r_clamp;

    // Clamp limit register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp <= CLAMP_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_CLAMP) begin
            r_clamp <= pwdata[7:0];
        end
    end
    assign prdata = (paddr[2] == REG_CLAMP) ? APB_DATA_W'(r_clamp) : '0;

    fbgl_front #(
        .GRID_DIM  (GRID_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_push     (push),
        .o_full     (full),
        .o_mid_push (mid_push),
        .o_mid_job  (mid_in),
        .i_mid_full (mid_full)
    );

    fbgl_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_out),
        .o_empty (mid_empty)
    );

    fbgl_back #(
        .GRID_DIM  (GRID_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (mid_out),
        .i_job_empty   (mid_empty),
        .o_job_pop     (mid_pop),
        .i_clamp_limit (r_clamp),
        .i_res_taken   (res_taken),
        .o_res_push    (res_push),
        .o_res         (res_item)
    );

    // Result queue
    assign res_taken = pop && !empty;

    fbgl_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_item),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty)
    );

    assign o_result = res_head;

    // Credit scheme must keep a slot free for every finished result
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res_push && res_full))
        else $error("result pushed into full result queue");

    // Front stage only drains into a queue with room
    a_mid_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mid_push && mid_full))
        else $error("job pushed into full middle queue");

    // Back end never pops an empty middle queue
    a_mid_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mid_pop && mid_empty))
        else $error("job popped from empty middle queue");

endmodule
